FILE: src/i2cra_pkg.sv
package i2cra_pkg;

	localparam int unsigned CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS_BYTE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TURNAROUND_TICKS    = 2'd1;

	localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h80;
	localparam logic [2:0] TURNAROUND_RESET     = 3'd5;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [6:0]  reg_index;
		logic [15:0] write_value;
		logic        sda_in;
	} i2cra_in_t;

	typedef struct packed {
		logic        scl_level;
		logic        sda_level;
		logic        sda_drive_enable;
		logic        busy_res;
		logic        done_res;
		logic        ack_error;
		logic [15:0] read_value;
	} i2cra_out_t;

endpackage

FILE: src/i2c_register_access_master_core.sv
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  in_data (kind, reg_index, write_value, sda_in)
// out       output     out_valid / out_stall out_data (lines, busy, done, error, read word)
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one tick per clock cycle while in_valid is high and in_stall low: the sequencer step
// is one pass of logic from the state registers into the result register
// in_stall is high only while the result register is full and out_stall holds it
// a completed bus transaction of n ticks costs n accepted items
// arst_n clears the sequencer to idle with scl and sda high and driven
module i2c_register_access_master_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  i2cra_pkg::i2cra_in_t          in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output i2cra_pkg::i2cra_out_t         out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [i2cra_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);
	import i2cra_pkg::*;

	localparam logic [4:0] PH_IDLE     = 5'd0;
	localparam logic [4:0] PH_START0   = 5'd1;
	localparam logic [4:0] PH_START1   = 5'd2;
	localparam logic [4:0] PH_START2   = 5'd3;
	localparam logic [4:0] PH_START3   = 5'd4;
	localparam logic [4:0] PH_TX_SET   = 5'd5;
	localparam logic [4:0] PH_TX_HIGH  = 5'd6;
	localparam logic [4:0] PH_TX_LOW   = 5'd7;
	localparam logic [4:0] PH_ACK_WAIT = 5'd8;
	localparam logic [4:0] PH_ACK_HIGH = 5'd9;
	localparam logic [4:0] PH_ACK_LOW  = 5'd10;
	localparam logic [4:0] PH_ACK_OUT  = 5'd11;
	localparam logic [4:0] PH_RX_WAIT  = 5'd12;
	localparam logic [4:0] PH_RX_HIGH  = 5'd13;
	localparam logic [4:0] PH_RX_LOW   = 5'd14;
	localparam logic [4:0] PH_RX_OUT   = 5'd15;
	localparam logic [4:0] PH_MA_SET   = 5'd16;
	localparam logic [4:0] PH_MA_HIGH  = 5'd17;
	localparam logic [4:0] PH_MA_LOW   = 5'd18;
	localparam logic [4:0] PH_STOP0    = 5'd19;
	localparam logic [4:0] PH_STOP1    = 5'd20;
	localparam logic [4:0] PH_STOP2    = 5'd21;
	localparam logic [4:0] PH_STOP3    = 5'd22;

	logic [7:0]  dev_addr_q;
	logic [2:0]  turn_q;
	logic [4:0]  phase_q, phase_n;
	logic [3:0]  bit_cnt_q, bit_cnt_n;
	logic [1:0]  byte_idx_q, byte_idx_n;
	logic [7:0]  shift_q, shift_n;
	logic [2:0]  wait_q, wait_n;
	logic [15:0] word_q, word_n;
	logic        rd_q, rd_n;
	logic [6:0]  reg_idx_q, reg_idx_n;
	logic [15:0] wr_val_q, wr_val_n;
	logic        nack_q, nack_n;
	logic        scl_q, scl_n;
	logic        sda_q, sda_n;
	logic        en_q, en_n;
	logic        in_accept;
	logic        out_valid_q;
	i2cra_out_t  out_data_q;
	i2cra_out_t  res;
	logic [2:0]  turn_len;
	logic [3:0]  bit_inc;
	logic        done_c;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign in_accept = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign turn_len  = (turn_q == 3'd0) ? 3'd1 : turn_q;
	assign bit_inc   = bit_cnt_q + 4'd1;

	always_comb begin
		phase_n    = phase_q;
		bit_cnt_n  = bit_cnt_q;
		byte_idx_n = byte_idx_q;
		shift_n    = shift_q;
		wait_n     = wait_q;
		word_n     = word_q;
		rd_n       = rd_q;
		reg_idx_n  = reg_idx_q;
		wr_val_n   = wr_val_q;
		nack_n     = nack_q;
		scl_n      = scl_q;
		sda_n      = sda_q;
		en_n       = en_q;
		done_c     = 1'b0;

		if (phase_q == PH_IDLE && (in_data.kind == KIND_WRITE || in_data.kind == KIND_READ)) begin
			rd_n       = (in_data.kind == KIND_READ);
			reg_idx_n  = in_data.reg_index;
			wr_val_n   = in_data.write_value;
			nack_n     = 1'b0;
			word_n     = '0;
			byte_idx_n = 2'd0;
			phase_n    = PH_START0;
		end

		unique case (phase_n)
			PH_IDLE: begin
			end
			PH_START0: begin
				sda_n = 1'b1; en_n = 1'b1; phase_n = PH_START1;
			end
			PH_START1: begin
				scl_n = 1'b1; phase_n = PH_START2;
			end
			PH_START2: begin
				sda_n = 1'b0; phase_n = PH_START3;
			end
			PH_START3: begin
				scl_n      = 1'b0;
				byte_idx_n = 2'd0;
				shift_n    = dev_addr_q;
				bit_cnt_n  = 4'd0;
				phase_n    = PH_TX_SET;
			end
			PH_TX_SET: begin
				sda_n = shift_q[7]; en_n = 1'b1; phase_n = PH_TX_HIGH;
			end
			PH_TX_HIGH: begin
				scl_n = 1'b1; phase_n = PH_TX_LOW;
			end
			PH_TX_LOW: begin
				scl_n     = 1'b0;
				shift_n   = {shift_q[6:0], 1'b0};
				bit_cnt_n = bit_inc;
				if (bit_inc < 4'd8) begin
					phase_n = PH_TX_SET;
				end else if (byte_idx_q == 2'd3) begin
					phase_n = PH_MA_SET;
				end else begin
					wait_n  = turn_len;
					phase_n = PH_ACK_WAIT;
				end
			end
			PH_ACK_WAIT, PH_RX_WAIT: begin
				en_n = 1'b0;
				if (wait_q > 3'd1) begin
					wait_n = wait_q - 3'd1;
				end else begin
					wait_n  = 3'd0;
					phase_n = (phase_q == PH_ACK_WAIT) ? PH_ACK_HIGH : PH_RX_HIGH;
				end
			end
			PH_ACK_HIGH: begin
				scl_n = 1'b1; phase_n = PH_ACK_LOW;
			end
			PH_ACK_LOW: begin
				if (in_data.sda_in) begin
					nack_n = 1'b1;
				end
				scl_n = 1'b0; phase_n = PH_ACK_OUT;
			end
			PH_ACK_OUT: begin
				en_n = 1'b1;
				if (nack_q) begin
					phase_n = PH_STOP0;
				end else if (byte_idx_q == 2'd0) begin
					byte_idx_n = 2'd1;
					shift_n    = {reg_idx_q, rd_q};
					bit_cnt_n  = 4'd0;
					phase_n    = PH_TX_SET;
				end else if (byte_idx_q == 2'd1) begin
					byte_idx_n = 2'd2;
					bit_cnt_n  = 4'd0;
					if (rd_q) begin
						shift_n = 8'd0;
						wait_n  = turn_len;
						phase_n = PH_RX_WAIT;
					end else begin
						shift_n = wr_val_q[15:8];
						phase_n = PH_TX_SET;
					end
				end else begin
					byte_idx_n = 2'd3;
					shift_n    = wr_val_q[7:0];
					bit_cnt_n  = 4'd0;
					phase_n    = PH_TX_SET;
				end
			end
			PH_RX_HIGH: begin
				scl_n = 1'b1; phase_n = PH_RX_LOW;
			end
			PH_RX_LOW: begin
				shift_n   = {shift_q[6:0], in_data.sda_in};
				scl_n     = 1'b0;
				bit_cnt_n = bit_inc;
				if (bit_inc < 4'd8) begin
					phase_n = PH_RX_HIGH;
				end else begin
					if (byte_idx_q == 2'd2) begin
						word_n = {shift_q[6:0], in_data.sda_in, word_q[7:0]};
					end else begin
						word_n = {word_q[15:8], shift_q[6:0], in_data.sda_in};
					end
					wait_n  = turn_len;
					phase_n = PH_RX_OUT;
				end
			end
			PH_RX_OUT: begin
				en_n = 1'b1;
				if (wait_q > 3'd1) begin
					wait_n = wait_q - 3'd1;
				end else begin
					wait_n  = 3'd0;
					phase_n = PH_MA_SET;
				end
			end
			PH_MA_SET: begin
				sda_n = ~(rd_q && byte_idx_q == 2'd2); en_n = 1'b1; phase_n = PH_MA_HIGH;
			end
			PH_MA_HIGH: begin
				scl_n = 1'b1; phase_n = PH_MA_LOW;
			end
			PH_MA_LOW: begin
				scl_n = 1'b0;
				if (rd_q && byte_idx_q == 2'd2) begin
					byte_idx_n = 2'd3;
					shift_n    = 8'd0;
					bit_cnt_n  = 4'd0;
					wait_n     = turn_len;
					phase_n    = PH_RX_WAIT;
				end else begin
					phase_n = PH_STOP0;
				end
			end
			PH_STOP0: begin
				scl_n = 1'b0; phase_n = PH_STOP1;
			end
			PH_STOP1: begin
				sda_n = 1'b0; en_n = 1'b1; phase_n = PH_STOP2;
			end
			PH_STOP2: begin
				scl_n = 1'b1; phase_n = PH_STOP3;
			end
			PH_STOP3: begin
				sda_n   = 1'b1;
				done_c  = 1'b1;
				phase_n = PH_IDLE;
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase

		res.scl_level        = scl_n;
		res.sda_level        = sda_n;
		res.sda_drive_enable = en_n;
		res.busy_res         = (phase_n != PH_IDLE);
		res.done_res         = done_c;
		res.ack_error        = done_c & nack_q;
		res.read_value       = (done_c && rd_q && !nack_q) ? word_q : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEVICE_ADDRESS_RESET;
			turn_q     <= TURNAROUND_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEVICE_ADDRESS_BYTE: dev_addr_q <= cfg_data;
				CFG_TURNAROUND_TICKS:    turn_q     <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			bit_cnt_q  <= '0;
			byte_idx_q <= '0;
			shift_q    <= '0;
			wait_q     <= '0;
			word_q     <= '0;
			rd_q       <= 1'b0;
			reg_idx_q  <= '0;
			wr_val_q   <= '0;
			nack_q     <= 1'b0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			en_q       <= 1'b1;
		end else if (in_accept) begin
			phase_q    <= phase_n;
			bit_cnt_q  <= bit_cnt_n;
			byte_idx_q <= byte_idx_n;
			shift_q    <= shift_n;
			wait_q     <= wait_n;
			word_q     <= word_n;
			rd_q       <= rd_n;
			reg_idx_q  <= reg_idx_n;
			wr_val_q   <= wr_val_n;
			nack_q     <= nack_n;
			scl_q      <= scl_n;
			sda_q      <= sda_n;
			en_q       <= en_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			out_data_q <= res;
		end
	end

	// a finished transaction leaves the sequencer idle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.done_res |-> !out_data_q.busy_res && phase_q == PH_IDLE)
		else $error("done reported while sequencer still busy");

	// error and read word only travel with done
	a_err_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_data_q.ack_error || out_data_q.read_value != 16'd0)
		|-> out_data_q.done_res)
		else $error("error or read data outside done");

	// result busy flag mirrors the stored phase
	a_busy_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_data_q.busy_res == (phase_q != PH_IDLE))
		else $error("busy flag disagrees with phase");

	// a held result keeps the sequencer frozen
	a_hold_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(phase_q) && $stable(bit_cnt_q))
		else $error("sequencer moved while result held");

	// bit counter never runs past one byte
	a_bit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q <= 4'd8)
		else $error("bit counter out of range");

endmodule
